### rtl/dsim_pkg.sv
package dsim_pkg;

    localparam int TRK_SECS    = 26;
    localparam int MAX_SECTORS = 4096;
    localparam int MAX_RESULTS = 64;

    // reciprocal of 26, exact for 12 bit logical sectors
    localparam int TRK_RECIP  = 2521;
    localparam int TRK_SHIFT  = 16;
    // reciprocal of 26, exact for 14 bit skew sums
    localparam int SKEW_RECIP = 20165;
    localparam int SKEW_SHIFT = 19;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLK_SECS          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HEADS         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEAD        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL_SKEW          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HD_SKEW           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_SECTORS = 3'd6;

    localparam logic        RST_INTERLEAVE_ENABLE = 1'b1;
    localparam logic [3:0]  RST_BLK_SECS          = 4'd4;
    localparam logic [4:0]  RST_NUM_HEADS         = 5'd1;
    localparam logic [3:0]  RST_FIRST_HEAD        = 4'd0;
    localparam logic [4:0]  RST_CYL_SKEW          = 5'd6;
    localparam logic [4:0]  RST_HD_SKEW           = 5'd0;
    localparam logic [12:0] RST_PARTITION_SECTORS = 13'd1976;

    localparam logic [4:0] TRACK_PATTERN [TRK_SECS] = '{
        5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22, 5'd24,
        5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd13, 5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25
    };

    typedef struct packed {
        logic [11:0] first_block;
        logic [3:0]  blk_cnt;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] sector_number;
        logic        last;
        logic        out_of_range;
    } t_out_beat;

    typedef struct packed {
        logic        interleave_enable;
        logic [3:0]  blk_secs;
        logic [4:0]  num_heads;
        logic [3:0]  first_head;
        logic [4:0]  cyl_skew;
        logic [4:0]  hd_skew;
        logic [12:0] partition_sectors;
    } t_cfg;

    // four restoring division steps: returns {remainder, quotient nibble}
    function automatic logic [8:0] div_nibble(input logic [4:0] rem_in,
                                              input logic [3:0] bits,
                                              input logic [4:0] dvs);
        logic [5:0] acc;
        logic [4:0] rem;
        logic [3:0] quo;
        rem = rem_in;
        quo = 4'd0;
        for (int k = 3; k >= 0; k--) begin
            acc = {rem, bits[k]};
            if (acc >= {1'b0, dvs}) begin
                acc    = acc - {1'b0, dvs};
                quo[k] = 1'b1;
            end
            rem = acc[4:0];
        end
        return {rem, quo};
    endfunction

endpackage

### rtl/disk_sector_interleave_mapper_top.sv
// Translates a request (first logical block, block count) into one beat per logical
// sector, in ascending order, carrying the physical sector within the partition, a
// last flag and an out-of-range flag. A request of n sectors (block count times
// sectors per block, capped at 64) keeps the input side not ready until its last sector
// has entered the pipeline: the sector sequencer issues one sector per cycle, unless
// stalled, into a seven stage pipeline (track split, skew walk count by restoring
// division, skew modulo, pattern rotation), and the results leave one per cycle while
// the output is not stalled. Output backpressure stalls the whole pipeline and the
// sequencer. A request with zero sectors gives no beats. Configuration must be written
// only while no request is in flight.
module disk_sector_interleave_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  dsim_pkg::t_in_beat                  i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output dsim_pkg::t_out_beat                 o_data,
    input  logic                                i_cfg_we,
    input  logic [dsim_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [dsim_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    dsim_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interleave_enable <= dsim_pkg::RST_INTERLEAVE_ENABLE;
            r_cfg.blk_secs          <= dsim_pkg::RST_BLK_SECS;
            r_cfg.num_heads         <= dsim_pkg::RST_NUM_HEADS;
            r_cfg.first_head        <= dsim_pkg::RST_FIRST_HEAD;
            r_cfg.cyl_skew          <= dsim_pkg::RST_CYL_SKEW;
            r_cfg.hd_skew           <= dsim_pkg::RST_HD_SKEW;
            r_cfg.partition_sectors <= dsim_pkg::RST_PARTITION_SECTORS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dsim_pkg::CFG_INTERLEAVE_ENABLE: r_cfg.interleave_enable <= i_cfg_data[0];
                dsim_pkg::CFG_BLK_SECS:          r_cfg.blk_secs          <= i_cfg_data[3:0];
                dsim_pkg::CFG_NUM_HEADS:         r_cfg.num_heads         <= i_cfg_data[4:0];
                dsim_pkg::CFG_FIRST_HEAD:        r_cfg.first_head        <= i_cfg_data[3:0];
                dsim_pkg::CFG_CYL_SKEW:          r_cfg.cyl_skew          <= i_cfg_data[4:0];
                dsim_pkg::CFG_HD_SKEW:           r_cfg.hd_skew           <= i_cfg_data[4:0];
                dsim_pkg::CFG_PARTITION_SECTORS: r_cfg.partition_sectors <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    logic        adv;
    logic        sec_valid;
    logic [15:0] sec_log;
    logic        sec_last;

    dsim_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_blk_secs  (r_cfg.blk_secs),
        .i_adv       (adv),
        .o_sec_valid (sec_valid),
        .o_sec_log   (sec_log),
        .o_sec_last  (sec_last)
    );

    dsim_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_sec_valid (sec_valid),
        .i_sec_log   (sec_log),
        .i_sec_last  (sec_last),
        .o_adv       (adv),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

### rtl/dsim_seq.sv
module dsim_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dsim_pkg::t_in_beat   i_data,
    input  logic [3:0]           i_blk_secs,
    input  logic                 i_adv,
    output logic                 o_sec_valid,
    output logic [15:0]          o_sec_log,
    output logic                 o_sec_last
);

    logic        r_busy;
    logic [15:0] r_log;
    logic [6:0]  r_left;
    logic [7:0]  total;
    logic [6:0]  clipped;
    logic [15:0] start;

    assign total   = {4'd0, i_data.blk_cnt} * {4'd0, i_blk_secs};
    assign clipped = (total > 8'(dsim_pkg::MAX_RESULTS)) ?
                     7'(dsim_pkg::MAX_RESULTS) : total[6:0];
    assign start   = {4'd0, i_data.first_block} * {12'd0, i_blk_secs};

    assign o_ready     = !r_busy;
    assign o_sec_valid = r_busy;
    assign o_sec_log   = r_log;
    assign o_sec_last  = (r_left == 7'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            if (i_valid) begin
                r_busy <= (clipped != 7'd0);
            end
        end else if (i_adv && o_sec_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_log  <= start;
            r_left <= clipped;
        end else if (i_adv) begin
            r_log  <= r_log + 16'd1;
            r_left <= r_left - 7'd1;
        end
    end

endmodule

### rtl/dsim_pipe.sv
module dsim_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dsim_pkg::t_cfg       i_cfg,
    input  logic                 i_sec_valid,
    input  logic [15:0]          i_sec_log,
    input  logic                 i_sec_last,
    output logic                 o_adv,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dsim_pkg::t_out_beat  o_data
);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_adv   = en;

    // stage 1: range check and track number
    logic        r1_v, r1_oor, r1_last;
    logic [11:0] r1_log;
    logic [7:0]  r1_trk;
    logic        s1_oor;
    logic [23:0] s1_prod;

    assign s1_oor  = (i_sec_log >= {3'd0, i_cfg.partition_sectors}) ||
                     (i_sec_log >= 16'(dsim_pkg::MAX_SECTORS));
    assign s1_prod = {12'd0, i_sec_log[11:0]} * 24'(dsim_pkg::TRK_RECIP);

    // stage 2: sector in track and division setup
    logic        r2_v, r2_oor, r2_last, r2_ge;
    logic [11:0] r2_log, r2_base;
    logic [7:0]  r2_trk, r2_num;
    logic [4:0]  r2_sec;
    logic [11:0] s2_base;
    logic [11:0] s2_secw;
    logic [4:0]  s2_first;
    logic        s2_ge;

    assign s2_base  = {4'd0, r1_trk} * 12'(dsim_pkg::TRK_SECS);
    assign s2_secw  = r1_log - s2_base;
    assign s2_first = ({1'b0, i_cfg.first_head} >= i_cfg.num_heads) ?
                      5'd1 : i_cfg.num_heads - {1'b0, i_cfg.first_head};
    assign s2_ge    = r1_trk >= {3'd0, s2_first};

    // head period of the skew walk
    logic [4:0] period;
    assign period = (i_cfg.num_heads == 5'd0) ? 5'd1 : i_cfg.num_heads;

    // stage 3: upper quotient nibble
    logic        r3_v, r3_oor, r3_last, r3_ge;
    logic [11:0] r3_log, r3_base;
    logic [7:0]  r3_trk;
    logic [4:0]  r3_sec, r3_rem;
    logic [3:0]  r3_qh, r3_lo;
    logic [8:0]  s3_div;

    assign s3_div = dsim_pkg::div_nibble(5'd0, r2_num[7:4], period);

    // stage 4: lower quotient nibble and cylinder change count
    logic        r4_v, r4_oor, r4_last;
    logic [11:0] r4_log, r4_base;
    logic [7:0]  r4_trk, r4_cyl;
    logic [4:0]  r4_sec;
    logic [8:0]  s4_div;
    logic [7:0]  s4_quo;

    assign s4_div = dsim_pkg::div_nibble(r3_rem, r3_lo, period);
    assign s4_quo = {r3_qh, s4_div[3:0]};

    // stage 5: raw skew sum
    logic        r5_v, r5_oor, r5_last;
    logic [11:0] r5_log, r5_base;
    logic [4:0]  r5_sec;
    logic [13:0] r5_sum;
    logic [7:0]  s5_hchg;
    logic [12:0] s5_cprod, s5_hprod;

    assign s5_hchg  = r4_trk - r4_cyl;
    assign s5_cprod = {5'd0, r4_cyl} * {8'd0, i_cfg.cyl_skew};
    assign s5_hprod = {5'd0, s5_hchg} * {8'd0, i_cfg.hd_skew};

    // stage 6: quotient of skew sum by the track length
    logic        r6_v, r6_oor, r6_last;
    logic [11:0] r6_log, r6_base;
    logic [4:0]  r6_sec;
    logic [13:0] r6_sum;
    logic [9:0]  r6_qm;
    logic [28:0] s6_prod;

    assign s6_prod = {15'd0, r5_sum} * 29'(dsim_pkg::SKEW_RECIP);

    // stage 7: rotate pattern and build result
    logic [14:0] s7_qm26;
    logic [13:0] s7_skw;
    logic [5:0]  s7_rot;
    logic [5:0]  s7_mod;
    logic [11:0] s7_phys;

    assign s7_qm26 = {5'd0, r6_qm} * 15'(dsim_pkg::TRK_SECS);
    assign s7_skw  = r6_sum - s7_qm26[13:0];
    assign s7_rot  = {1'b0, dsim_pkg::TRACK_PATTERN[r6_sec]} + {1'b0, s7_skw[4:0]};
    assign s7_mod  = (s7_rot >= 6'(dsim_pkg::TRK_SECS)) ?
                     s7_rot - 6'(dsim_pkg::TRK_SECS) : s7_rot;
    assign s7_phys = r6_oor ? 12'd0 :
                     i_cfg.interleave_enable ? r6_base + {7'd0, s7_mod[4:0]} : r6_log;

    logic r7_v;
    dsim_pkg::t_out_beat r7_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_sec_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_oor  <= s1_oor;
            r1_last <= i_sec_last;
            r1_log  <= i_sec_log[11:0];
            r1_trk  <= s1_prod[dsim_pkg::TRK_SHIFT+7:dsim_pkg::TRK_SHIFT];

            r2_oor  <= r1_oor;
            r2_last <= r1_last;
            r2_log  <= r1_log;
            r2_base <= s2_base;
            r2_trk  <= r1_trk;
            r2_sec  <= s2_secw[4:0];
            r2_ge   <= s2_ge;
            r2_num  <= r1_trk - {3'd0, s2_first};

            r3_oor  <= r2_oor;
            r3_last <= r2_last;
            r3_log  <= r2_log;
            r3_base <= r2_base;
            r3_trk  <= r2_trk;
            r3_sec  <= r2_sec;
            r3_ge   <= r2_ge;
            r3_rem  <= s3_div[8:4];
            r3_qh   <= s3_div[3:0];
            r3_lo   <= r2_num[3:0];

            r4_oor  <= r3_oor;
            r4_last <= r3_last;
            r4_log  <= r3_log;
            r4_base <= r3_base;
            r4_trk  <= r3_trk;
            r4_sec  <= r3_sec;
            r4_cyl  <= r3_ge ? s4_quo + 8'd1 : 8'd0;

            r5_oor  <= r4_oor;
            r5_last <= r4_last;
            r5_log  <= r4_log;
            r5_base <= r4_base;
            r5_sec  <= r4_sec;
            r5_sum  <= {1'b0, s5_cprod} + {1'b0, s5_hprod};

            r6_oor  <= r5_oor;
            r6_last <= r5_last;
            r6_log  <= r5_log;
            r6_base <= r5_base;
            r6_sec  <= r5_sec;
            r6_sum  <= r5_sum;
            r6_qm   <= s6_prod[dsim_pkg::SKEW_SHIFT+9:dsim_pkg::SKEW_SHIFT];

            r7_data.sector_number <= s7_phys;
            r7_data.last          <= r6_last;
            r7_data.out_of_range  <= r6_oor;
        end
    end

    assign o_valid = r7_v;
    assign o_data  = r7_data;

endmodule
